// ===== rtl/sparse_jacobi_value_iteration_core_defines.svh =====
// Assertion macros used by the core's engine.
`ifndef SPARSE_JACOBI_VALUE_ITERATION_CORE_DEFINES_SVH
`define SPARSE_JACOBI_VALUE_ITERATION_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SJVI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SJVI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SJVI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SJVI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/sjvi_pkg.sv =====
`default_nettype none
package sjvi_pkg;

    localparam int VALUE_W    = 64;
    localparam int PROB_W     = 33;
    localparam int ROW_END_W  = 15;
    localparam int COLUMN_W   = 10;
    localparam int INDEX_W    = 14;
    localparam int SWEEP_W    = 20;
    localparam int RESID_W    = 63;
    localparam int NCFG_W     = 11;
    localparam int CFG_DATA_W = 33;
    localparam int CFG_IDX_W  = 2;

    localparam logic [PROB_W-1:0]  ONE_Q32 = 33'h1_0000_0000;
    localparam logic [RESID_W-1:0] MAX63   = {RESID_W{1'b1}};

    typedef enum logic [1:0] {
        OP_LOAD_ROW = 2'd0,
        OP_LOAD_NZ  = 2'd1,
        OP_RUN      = 2'd2,
        OP_READ     = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_N_STATES   = 2'd0,
        CFG_DISCOUNT   = 2'd1,
        CFG_EPS        = 2'd2,
        CFG_MAX_SWEEPS = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_ROW,
        ST_ROW_DATA,
        ST_NZ,
        ST_NZ_COL,
        ST_NZ_X,
        ST_NZ_LO,
        ST_NZ_HI,
        ST_NZ_ACC,
        ST_FIN_DATA,
        ST_SWEEP,
        ST_READ,
        ST_EMIT
    } state_t;

    typedef struct packed {
        op_t                  op;
        logic [INDEX_W-1:0]   index;
        logic [VALUE_W-1:0]   reward;
        logic [ROW_END_W-1:0] row_end;
        logic [COLUMN_W-1:0]  column;
        logic [PROB_W-1:0]    prob;
    } item_t;

    typedef struct packed {
        logic                 kind;
        logic [VALUE_W-1:0]   value;
        logic                 converged;
        logic [SWEEP_W-1:0]   sweeps;
        logic [RESID_W-1:0]   residual;
    } rsp_t;

endpackage
`default_nettype wire

// ===== rtl/sjvi_fifo.sv =====
`default_nettype none
module sjvi_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr,
    input  wire logic [W-1:0] din,
    output logic              full,
    input  wire logic         rd,
    output logic [W-1:0]      dout,
    output logic              empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr, do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign dout  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sjvi_front.sv =====
`default_nettype none
module sjvi_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [1:0]                      command,
    input  wire logic [sjvi_pkg::INDEX_W-1:0]    index,
    input  wire logic [sjvi_pkg::VALUE_W-1:0]    reward,
    input  wire logic [sjvi_pkg::ROW_END_W-1:0]  row_end,
    input  wire logic [sjvi_pkg::COLUMN_W-1:0]   column,
    input  wire logic [sjvi_pkg::PROB_W-1:0]     prob,
    output sjvi_pkg::item_t                      item,
    output logic                                 item_valid,
    input  wire logic                            item_pop
);

    sjvi_pkg::item_t dec;
    logic            q_empty;

    // decode: command to opcode, probability clamped to 1.0
    always_comb
    begin
        dec.op      = sjvi_pkg::op_t'(command);
        dec.index   = index;
        dec.reward  = reward;
        dec.row_end = row_end;
        dec.column  = column;
        dec.prob    = (prob > sjvi_pkg::ONE_Q32) ? sjvi_pkg::ONE_Q32 : prob;
    end

    sjvi_fifo #(
        .W     ($bits(sjvi_pkg::item_t)),
        .DEPTH (2)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (push),
        .din   (dec),
        .full  (full),
        .rd    (item_pop),
        .dout  (item),
        .empty (q_empty)
    );

    assign item_valid = !q_empty;

endmodule
`default_nettype wire

// ===== rtl/sjvi_engine.sv =====
`default_nettype none
`include "sparse_jacobi_value_iteration_core_defines.svh"
module sjvi_engine #(
    parameter int MAX_STATES   = 1024,
    parameter int MAX_NONZEROS = 16384
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [sjvi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sjvi_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  sjvi_pkg::item_t                        item,
    input  wire logic                              item_valid,
    output logic                                   item_pop,
    output sjvi_pkg::rsp_t                         rsp,
    output logic                                   rsp_push,
    input  wire logic                              rsp_full,
    output logic                                   init_busy
);

    localparam int SW  = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int NW  = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
    localparam int VW  = sjvi_pkg::VALUE_W;
    localparam int PW  = sjvi_pkg::PROB_W;
    localparam int RW  = sjvi_pkg::ROW_END_W;
    localparam int CLW = sjvi_pkg::COLUMN_W;
    localparam int NCW = sjvi_pkg::NCFG_W;
    localparam int SWW = sjvi_pkg::SWEEP_W;
    localparam int RSW = sjvi_pkg::RESID_W;

    function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic [VW-1:0] s;
        s = a + b;
        if ((a[VW-1] == b[VW-1]) && (s[VW-1] != a[VW-1]))
        begin
            s = a[VW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end
        return s;
    endfunction

    function automatic logic [RSW-1:0] abs_diff(input logic [VW-1:0] a, input logic [VW-1:0] b);
        logic [VW-1:0] d;
        d = ($signed(a) >= $signed(b)) ? a - b : b - a;
        return d[VW-1] ? sjvi_pkg::MAX63 : d[RSW-1:0];
    endfunction

    // configuration
    logic [NCW-1:0] cfg_n_reg;
    logic [PW-1:0]  cfg_discount_reg;
    logic [PW-1:0]  cfg_eps_reg;
    logic [SWW-1:0] cfg_max_sweeps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_n_reg          <= NCW'(1);
            cfg_discount_reg   <= PW'(64'd4252017623);
            cfg_eps_reg        <= PW'(43);
            cfg_max_sweeps_reg <= SWW'(65535);
        end
        else if (cfg_write)
        begin
            case (sjvi_pkg::cfg_idx_t'(cfg_index))
                sjvi_pkg::CFG_N_STATES:   cfg_n_reg          <= cfg_data[NCW-1:0];
                sjvi_pkg::CFG_DISCOUNT:   cfg_discount_reg   <= cfg_data;
                sjvi_pkg::CFG_EPS:        cfg_eps_reg        <= cfg_data;
                sjvi_pkg::CFG_MAX_SWEEPS: cfg_max_sweeps_reg <= cfg_data[SWW-1:0];
                default: ;
            endcase
        end
    end

    // memories
    logic [VW-1:0]  reward_mem [MAX_STATES];
    logic [RW-1:0]  row_end_mem [MAX_STATES];
    logic [CLW-1:0] column_mem [MAX_NONZEROS];
    logic [PW-1:0]  prob_mem [MAX_NONZEROS];
    logic [VW-1:0]  bank_a_mem [MAX_STATES];
    logic [VW-1:0]  bank_b_mem [MAX_STATES];

    logic [VW-1:0]  reward_rd_reg, bank_a_rd_reg, bank_b_rd_reg;
    logic [RW-1:0]  row_end_rd_reg;
    logic [CLW-1:0] column_rd_reg;
    logic [PW-1:0]  prob_rd_reg;

    logic           st_we, nz_we, bank_a_we, bank_b_we;
    logic [SW-1:0]  st_addr, bank_waddr, bank_raddr;
    logic [NW-1:0]  nz_addr;
    logic [VW-1:0]  bank_wdata;

    // FSM registers
    sjvi_pkg::state_t state_reg, state_next;
    logic [SW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [NCW-1:0] i_reg, i_next, n_reg, n_next;
    logic [RW-1:0]  k_reg, k_next, end_reg, end_next, start_reg, start_next;
    logic [VW-1:0]  acc_reg, acc_next, mag_reg, mag_next, t_reg, t_next;
    logic [RSW-1:0] maxd_reg, maxd_next;
    logic [SWW-1:0] sweeps_reg, sweeps_next;
    logic           bank_reg, bank_next, neg_reg, neg_next;
    logic           read_ok_reg, read_ok_next;
    logic [PW-1:0]  beta_reg, beta_next, coef_reg, coef_next, plo_reg, plo_next;
    sjvi_pkg::rsp_t rsp_reg, rsp_next;

    logic [31:0]    item_idx32, i32, k32, col32;
    logic [VW-1:0]  x_rd, term;
    logic [2*PW-1:0] coef_prod;
    logic [PW+31:0] lo_prod, hi_prod;
    logic [RSW-1:0] d_row;
    logic [SWW-1:0] sweeps_inc;
    logic           item_st_ok, item_nz_ok, stop;

    assign item_idx32 = 32'(item.index);
    assign i32        = 32'(i_reg);
    assign k32        = 32'(k_reg);
    assign col32      = 32'(column_rd_reg);
    assign item_st_ok = item_idx32 < MAX_STATES;
    assign item_nz_ok = item_idx32 < MAX_NONZEROS;

    assign x_rd       = bank_reg ? bank_b_rd_reg : bank_a_rd_reg;
    assign coef_prod  = {{PW{1'b0}}, beta_reg} * {{PW{1'b0}}, prob_rd_reg};
    assign lo_prod    = {{PW{1'b0}}, mag_reg[31:0]} * {32'b0, coef_reg};
    assign hi_prod    = {{PW{1'b0}}, mag_reg[63:32]} * {32'b0, coef_reg};
    assign term       = neg_reg ? (~t_reg + VW'(1)) : t_reg;
    assign d_row      = abs_diff(acc_reg, x_rd);
    assign sweeps_inc = sweeps_reg + SWW'(1);
    assign stop       = (maxd_reg <= RSW'(cfg_eps_reg)) || (sweeps_inc >= cfg_max_sweeps_reg);

    assign init_busy  = (state_reg == sjvi_pkg::ST_INIT);
    assign rsp        = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            reward_mem[st_addr]  <= item.reward;
            row_end_mem[st_addr] <= item.row_end;
        end
        reward_rd_reg  <= reward_mem[st_addr];
        row_end_rd_reg <= row_end_mem[st_addr];
    end

    always_ff @(posedge clk)
    begin
        if (nz_we)
        begin
            column_mem[nz_addr] <= item.column;
            prob_mem[nz_addr]   <= item.prob;
        end
        column_rd_reg <= column_mem[nz_addr];
        prob_rd_reg   <= prob_mem[nz_addr];
    end

    always_ff @(posedge clk)
    begin
        if (bank_a_we)
        begin
            bank_a_mem[bank_waddr] <= bank_wdata;
        end
        bank_a_rd_reg <= bank_a_mem[bank_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (bank_b_we)
        begin
            bank_b_mem[bank_waddr] <= bank_wdata;
        end
        bank_b_rd_reg <= bank_b_mem[bank_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sjvi_pkg::ST_INIT;
            clr_cnt_reg <= '0;
            bank_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            bank_reg    <= bank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg       <= i_next;
        n_reg       <= n_next;
        k_reg       <= k_next;
        end_reg     <= end_next;
        start_reg   <= start_next;
        acc_reg     <= acc_next;
        mag_reg     <= mag_next;
        t_reg       <= t_next;
        maxd_reg    <= maxd_next;
        sweeps_reg  <= sweeps_next;
        neg_reg     <= neg_next;
        read_ok_reg <= read_ok_next;
        beta_reg    <= beta_next;
        coef_reg    <= coef_next;
        plo_reg     <= plo_next;
        rsp_reg     <= rsp_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        i_next       = i_reg;
        n_next       = n_reg;
        k_next       = k_reg;
        end_next     = end_reg;
        start_next   = start_reg;
        acc_next     = acc_reg;
        mag_next     = mag_reg;
        t_next       = t_reg;
        maxd_next    = maxd_reg;
        sweeps_next  = sweeps_reg;
        bank_next    = bank_reg;
        neg_next     = neg_reg;
        read_ok_next = read_ok_reg;
        beta_next    = beta_reg;
        coef_next    = coef_reg;
        plo_next     = plo_reg;
        rsp_next     = rsp_reg;

        item_pop   = 1'b0;
        rsp_push   = 1'b0;
        st_we      = 1'b0;
        nz_we      = 1'b0;
        bank_a_we  = 1'b0;
        bank_b_we  = 1'b0;
        bank_wdata = '0;
        bank_waddr = clr_cnt_reg;
        bank_raddr = i32[SW-1:0];
        st_addr    = i32[SW-1:0];
        nz_addr    = k32[NW-1:0];

        case (state_reg)
            sjvi_pkg::ST_INIT,
            sjvi_pkg::ST_CLEAR:
            begin
                // zero both banks, one entry a cycle
                bank_a_we = 1'b1;
                bank_b_we = 1'b1;
                if (clr_cnt_reg == SW'(MAX_STATES - 1))
                begin
                    clr_cnt_next = '0;
                    if (state_reg == sjvi_pkg::ST_INIT)
                    begin
                        state_next = sjvi_pkg::ST_IDLE;
                    end
                    else
                    begin
                        bank_next   = 1'b0;
                        sweeps_next = '0;
                        i_next      = '0;
                        start_next  = '0;
                        maxd_next   = '0;
                        if (cfg_max_sweeps_reg == '0)
                        begin
                            rsp_next.kind      = 1'b0;
                            rsp_next.value     = '0;
                            rsp_next.converged = sjvi_pkg::MAX63 <= RSW'(cfg_eps_reg);
                            rsp_next.sweeps    = '0;
                            rsp_next.residual  = sjvi_pkg::MAX63;
                            state_next         = sjvi_pkg::ST_EMIT;
                        end
                        else
                        begin
                            state_next = sjvi_pkg::ST_ROW;
                        end
                    end
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + SW'(1);
                end
            end

            sjvi_pkg::ST_IDLE:
            begin
                st_addr = item_idx32[SW-1:0];
                nz_addr = item_idx32[NW-1:0];
                if (item_valid)
                begin
                    item_pop = 1'b1;
                    case (item.op)
                        sjvi_pkg::OP_LOAD_ROW: st_we = item_st_ok;
                        sjvi_pkg::OP_LOAD_NZ:  nz_we = item_nz_ok;
                        sjvi_pkg::OP_RUN:
                        begin
                            if (cfg_n_reg == '0)
                            begin
                                n_next = NCW'(1);
                            end
                            else if (32'(cfg_n_reg) > MAX_STATES)
                            begin
                                n_next = NCW'(MAX_STATES);
                            end
                            else
                            begin
                                n_next = cfg_n_reg;
                            end
                            beta_next  = (cfg_discount_reg > sjvi_pkg::ONE_Q32) ?
                                         sjvi_pkg::ONE_Q32 : cfg_discount_reg;
                            state_next = sjvi_pkg::ST_CLEAR;
                        end
                        sjvi_pkg::OP_READ:
                        begin
                            bank_raddr   = item_idx32[SW-1:0];
                            read_ok_next = item_st_ok;
                            state_next   = sjvi_pkg::ST_READ;
                        end
                        default: ;
                    endcase
                end
            end

            sjvi_pkg::ST_ROW:
            begin
                state_next = sjvi_pkg::ST_ROW_DATA;
            end

            sjvi_pkg::ST_ROW_DATA:
            begin
                acc_next   = reward_rd_reg;
                end_next   = (32'(row_end_rd_reg) > MAX_NONZEROS) ?
                             RW'(MAX_NONZEROS) : row_end_rd_reg;
                k_next     = start_reg;
                start_next = row_end_rd_reg;
                state_next = sjvi_pkg::ST_NZ;
            end

            sjvi_pkg::ST_NZ:
            begin
                // nonzero fetch, or old x[i] fetch when the row is done
                if (k_reg < end_reg)
                begin
                    state_next = sjvi_pkg::ST_NZ_COL;
                end
                else
                begin
                    state_next = sjvi_pkg::ST_FIN_DATA;
                end
            end

            sjvi_pkg::ST_NZ_COL:
            begin
                if (col32 >= MAX_STATES)
                begin
                    k_next     = k_reg + RW'(1);
                    state_next = sjvi_pkg::ST_NZ;
                end
                else
                begin
                    bank_raddr = col32[SW-1:0];
                    coef_next  = coef_prod[PW+31:32];
                    state_next = sjvi_pkg::ST_NZ_X;
                end
            end

            sjvi_pkg::ST_NZ_X:
            begin
                neg_next   = x_rd[VW-1];
                mag_next   = x_rd[VW-1] ? (~x_rd + VW'(1)) : x_rd;
                state_next = sjvi_pkg::ST_NZ_LO;
            end

            sjvi_pkg::ST_NZ_LO:
            begin
                plo_next   = lo_prod[PW+31:32];
                state_next = sjvi_pkg::ST_NZ_HI;
            end

            sjvi_pkg::ST_NZ_HI:
            begin
                t_next     = hi_prod[VW-1:0] + VW'(plo_reg);
                state_next = sjvi_pkg::ST_NZ_ACC;
            end

            sjvi_pkg::ST_NZ_ACC:
            begin
                acc_next   = sat_add(acc_reg, term);
                k_next     = k_reg + RW'(1);
                state_next = sjvi_pkg::ST_NZ;
            end

            sjvi_pkg::ST_FIN_DATA:
            begin
                bank_waddr = i32[SW-1:0];
                bank_wdata = acc_reg;
                bank_a_we  = bank_reg;
                bank_b_we  = !bank_reg;
                if (d_row > maxd_reg)
                begin
                    maxd_next = d_row;
                end
                i_next = i_reg + NCW'(1);
                if (i_next == n_reg)
                begin
                    state_next = sjvi_pkg::ST_SWEEP;
                end
                else
                begin
                    state_next = sjvi_pkg::ST_ROW;
                end
            end

            sjvi_pkg::ST_SWEEP:
            begin
                bank_next   = !bank_reg;
                sweeps_next = sweeps_inc;
                if (stop)
                begin
                    rsp_next.kind      = 1'b0;
                    rsp_next.value     = '0;
                    rsp_next.converged = maxd_reg <= RSW'(cfg_eps_reg);
                    rsp_next.sweeps    = sweeps_inc;
                    rsp_next.residual  = maxd_reg;
                    state_next         = sjvi_pkg::ST_EMIT;
                end
                else
                begin
                    i_next     = '0;
                    start_next = '0;
                    maxd_next  = '0;
                    state_next = sjvi_pkg::ST_ROW;
                end
            end

            sjvi_pkg::ST_READ:
            begin
                rsp_next.kind      = 1'b1;
                rsp_next.value     = read_ok_reg ? x_rd : '0;
                rsp_next.converged = 1'b0;
                rsp_next.sweeps    = '0;
                rsp_next.residual  = '0;
                state_next         = sjvi_pkg::ST_EMIT;
            end

            sjvi_pkg::ST_EMIT:
            begin
                if (!rsp_full)
                begin
                    rsp_push   = 1'b1;
                    state_next = sjvi_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sjvi_pkg::ST_IDLE;
            end
        endcase
    end

    `SJVI_ASSERT_IMP(a_push_has_room, clk, rst_n, rsp_push, !rsp_full)
    `SJVI_ASSERT_IMP(a_pop_has_item, clk, rst_n, item_pop, item_valid && state_reg == sjvi_pkg::ST_IDLE)
    `SJVI_ASSERT_IMP(a_one_bank_write, clk, rst_n, state_reg == sjvi_pkg::ST_FIN_DATA, bank_a_we != bank_b_we)
    `SJVI_ASSERT_NEXT(a_push_to_idle, clk, rst_n, rsp_push, state_reg == sjvi_pkg::ST_IDLE)

endmodule
`default_nettype wire

// ===== rtl/sparse_jacobi_value_iteration_core.sv =====
// Sparse Jacobi value iteration core (CSR policy evaluation, Q31.32).
// Command channel: push/full, a transfer when push is high and full low.
//   command 0 loads reward and row end of a state, 1 loads column and
//   probability of a nonzero, 2 runs a solve, 3 reads one current value.
// Result channel: empty/pop, a transfer when pop is high and empty low.
//   Run gives a status result, read gives a value result; loads give none.
// Config: cfg_write/cfg_index/cfg_data, taken the same cycle; write only
//   while the core is idle.
// Flow: the engine walks commands one at a time through a 2-deep command
//   queue. A run zeroes both value banks, then per sweep walks each row
//   (row fetch, row data, nonzero check, finish) and each nonzero of it
//   (column, value, low product, high product, accumulate); a nonzero
//   whose column is out of range is skipped after its column fetch.
// Reset: a clearing pass over all MAX_STATES entries zeroes the value banks;
//   full stays high until it ends. Load stores are undefined until written.
// Stall: results sit in a 2-deep result queue; with it full the engine holds
//   its finished result and the command queue fills, raising full.
`default_nettype none
module sparse_jacobi_value_iteration_core #(
    parameter int MAX_STATES   = 1024,
    parameter int MAX_NONZEROS = 16384
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic [1:0]                         command,
    input  wire logic [sjvi_pkg::INDEX_W-1:0]       index,
    input  wire logic signed [sjvi_pkg::VALUE_W-1:0] reward,
    input  wire logic [sjvi_pkg::ROW_END_W-1:0]     row_end,
    input  wire logic [sjvi_pkg::COLUMN_W-1:0]      column,
    input  wire logic [sjvi_pkg::PROB_W-1:0]        prob,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic                                    result_kind,
    output logic signed [sjvi_pkg::VALUE_W-1:0]     value,
    output logic                                    converged,
    output logic [sjvi_pkg::SWEEP_W-1:0]            sweeps_done,
    output logic [sjvi_pkg::RESID_W-1:0]            residual,
    input  wire logic                               cfg_write,
    input  wire logic [sjvi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sjvi_pkg::CFG_DATA_W-1:0]    cfg_data
);

    sjvi_pkg::item_t item;
    sjvi_pkg::rsp_t  rsp, rsp_q;
    logic            item_valid, item_pop, rsp_push, rsp_full, init_busy, front_full;

    assign full = front_full || init_busy;

    sjvi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push && !full),
        .full       (front_full),
        .command    (command),
        .index      (index),
        .reward     (reward),
        .row_end    (row_end),
        .column     (column),
        .prob       (prob),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop)
    );

    sjvi_engine #(
        .MAX_STATES   (MAX_STATES),
        .MAX_NONZEROS (MAX_NONZEROS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .rsp        (rsp),
        .rsp_push   (rsp_push),
        .rsp_full   (rsp_full),
        .init_busy  (init_busy)
    );

    // result queue decouples the engine from the consumer
    sjvi_fifo #(
        .W     ($bits(sjvi_pkg::rsp_t)),
        .DEPTH (2)
    ) u_rsp_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (rsp_push),
        .din   (rsp),
        .full  (rsp_full),
        .rd    (pop),
        .dout  (rsp_q),
        .empty (empty)
    );

    assign result_kind = rsp_q.kind;
    assign value       = rsp_q.value;
    assign converged   = rsp_q.converged;
    assign sweeps_done = rsp_q.sweeps;
    assign residual    = rsp_q.residual;

endmodule
`default_nettype wire

// ===== bench/sparse_jacobi_value_iteration_core_test.sv =====
`default_nettype none
module sparse_jacobi_value_iteration_core_test;

    localparam int NSTATES = 1024;
    localparam int NNZ     = 16384;
    // Cycles without any transfer before the run is declared hung. The slowest
    // legal run here (1024-state clear plus a few thousand sweeps of a
    // one-row problem) stays far below this.
    localparam int IDLE_LIMIT = 400000;
    localparam logic [63:0] Q_ONE = 64'h1_0000_0000;
    localparam logic [63:0] S_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] S_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic [1:0] command;
    logic [sjvi_pkg::INDEX_W-1:0] index;
    logic signed [sjvi_pkg::VALUE_W-1:0] reward;
    logic [sjvi_pkg::ROW_END_W-1:0] row_end;
    logic [sjvi_pkg::COLUMN_W-1:0] column;
    logic [sjvi_pkg::PROB_W-1:0] prob;
    logic empty;
    logic pop;
    logic result_kind;
    logic signed [sjvi_pkg::VALUE_W-1:0] value;
    logic converged;
    logic [sjvi_pkg::SWEEP_W-1:0] sweeps_done;
    logic [sjvi_pkg::RESID_W-1:0] residual;
    logic cfg_write;
    logic [sjvi_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [sjvi_pkg::CFG_DATA_W-1:0] cfg_data;

    sparse_jacobi_value_iteration_core u_top (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full),
        .command(command), .index(index), .reward(reward), .row_end(row_end),
        .column(column), .prob(prob),
        .empty(empty), .pop(pop),
        .result_kind(result_kind), .value(value), .converged(converged),
        .sweeps_done(sweeps_done), .residual(residual),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // ---------------------------------------------------------------------
    // Mirror of the core: load stores, both value banks and registers.
    // ---------------------------------------------------------------------
    logic [63:0] m_reward [NSTATES];
    logic [14:0] m_row_end [NSTATES];
    logic [9:0]  m_column [NNZ];
    logic [32:0] m_prob [NNZ];
    logic [63:0] bank_a [NSTATES];
    logic [63:0] bank_b [NSTATES];
    logic        bank_sel;
    logic [10:0] r_n_states;
    logic [32:0] r_discount;
    logic [32:0] r_eps;
    logic [19:0] r_max_sweeps;

    sjvi_pkg::rsp_t pending_results [$];
    int   error_count;
    int   items_sent;
    int   idle_cycles;

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            s = a[63] ? S_MIN : S_MAX;
        return s;
    endfunction

    function automatic logic [63:0] abs_change(logic [63:0] a, logic [63:0] b);
        logic [63:0] d;
        d = ($signed(a) >= $signed(b)) ? a - b : b - a;
        return (d > S_MAX) ? S_MAX : d;
    endfunction

    // mag * c >> 32, truncated, split so nothing overflows 64 bits
    function automatic logic [63:0] scale_q32(logic [63:0] mag, logic [63:0] c);
        logic [63:0] hi;
        logic [63:0] lo;
        hi = mag >> 32;
        lo = {32'd0, mag[31:0]};
        return hi * c + ((lo * c) >> 32);
    endfunction

    function automatic sjvi_pkg::rsp_t solve_values();
        sjvi_pkg::rsp_t r;
        int unsigned n;
        int unsigned sweeps;
        int unsigned start;
        int unsigned stop;
        logic [63:0] beta;
        logic [63:0] resid;
        logic [63:0] maxd;
        logic [63:0] acc;
        logic [63:0] coef;
        logic [63:0] v;
        logic [63:0] mag;
        logic [63:0] t;
        logic [63:0] old;
        logic [63:0] d;
        n = r_n_states;
        if (n < 1) n = 1;
        if (n > NSTATES) n = NSTATES;
        beta = (r_discount > Q_ONE) ? Q_ONE : {31'd0, r_discount};
        for (int i = 0; i < NSTATES; i++)
        begin
            bank_a[i] = '0;
            bank_b[i] = '0;
        end
        bank_sel = 1'b0;
        resid = S_MAX;
        sweeps = 0;
        while (sweeps < r_max_sweeps)
        begin
            maxd = '0;
            for (int i = 0; i < n; i++)
            begin
                start = (i == 0) ? 0 : m_row_end[i-1];
                stop = m_row_end[i];
                if (stop > NNZ) stop = NNZ;
                acc = m_reward[i];
                for (int unsigned k = start; k < stop; k++)
                begin
                    coef = (beta == Q_ONE) ? {31'd0, m_prob[k]}
                                           : (beta * {31'd0, m_prob[k]}) >> 32;
                    v = bank_sel ? bank_b[m_column[k]] : bank_a[m_column[k]];
                    mag = v[63] ? -v : v;
                    t = scale_q32(mag, coef);
                    if (v[63]) t = -t;
                    acc = sat_add(acc, t);
                end
                old = bank_sel ? bank_b[i] : bank_a[i];
                if (bank_sel) bank_a[i] = acc;
                else bank_b[i] = acc;
                d = abs_change(acc, old);
                if (d > maxd) maxd = d;
            end
            bank_sel = ~bank_sel;
            resid = maxd;
            sweeps++;
            if (resid <= {31'd0, r_eps}) break;
        end
        r.kind = 1'b0;
        r.value = '0;
        r.converged = (resid <= {31'd0, r_eps});
        r.sweeps = sweeps[19:0];
        r.residual = resid[62:0];
        return r;
    endfunction

    // Applies one accepted command to the mirror; returns 1 if it makes a result.
    function automatic bit predict_command(sjvi_pkg::item_t it, output sjvi_pkg::rsp_t r);
        r = '0;
        case (it.op)
            sjvi_pkg::OP_LOAD_ROW:
            begin
                if (it.index < NSTATES)
                begin
                    m_reward[it.index] = it.reward;
                    m_row_end[it.index] = it.row_end;
                end
                return 0;
            end
            sjvi_pkg::OP_LOAD_NZ:
            begin
                m_column[it.index] = it.column;
                m_prob[it.index] = (it.prob > sjvi_pkg::ONE_Q32) ? sjvi_pkg::ONE_Q32 : it.prob;
                return 0;
            end
            sjvi_pkg::OP_RUN:
            begin
                r = solve_values();
                return 1;
            end
            default:
            begin
                r.kind = 1'b1;
                if (it.index < NSTATES)
                    r.value = bank_sel ? bank_b[it.index] : bank_a[it.index];
                return 1;
            end
        endcase
    endfunction

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s: got %h, expected %h", field, got, want);
        error_count++;
    endtask

    // ---------------------------------------------------------------------
    // Clock, reset, watchdog
    // ---------------------------------------------------------------------
    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL sparse_jacobi_value_iteration_core");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result side: checks each transfer against the oldest expectation,
    // then picks the next pop level from a slowly changing stall mode.
    // ---------------------------------------------------------------------
    int pop_mode;
    int pop_mode_left;

    always @(posedge clk)
    begin
        sjvi_pkg::rsp_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
                report("unexpected result", {63'd0, result_kind}, 64'd0);
            else
            begin
                want = pending_results.pop_front();
                if (result_kind !== want.kind)
                    report("result_kind", {63'd0, result_kind}, {63'd0, want.kind});
                if (value !== want.value)
                    report("value", value, want.value);
                if (converged !== want.converged)
                    report("converged", {63'd0, converged}, {63'd0, want.converged});
                if (sweeps_done !== want.sweeps)
                    report("sweeps_done", {44'd0, sweeps_done}, {44'd0, want.sweeps});
                if (residual !== want.residual)
                    report("residual", {1'b0, residual}, {1'b0, want.residual});
            end
        end
        if (pop_mode_left == 0)
        begin
            pop_mode <= $urandom_range(0, 2);
            pop_mode_left <= $urandom_range(1, 40);
        end
        else
            pop_mode_left <= pop_mode_left - 1;
        case (pop_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            default: pop <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ---------------------------------------------------------------------
    // Command side
    // ---------------------------------------------------------------------
    int burst_left;

    // Drives one command in bursts with random gaps; returns once it transfers.
    task automatic send(sjvi_pkg::item_t it, bit zero_read);
        sjvi_pkg::rsp_t r;
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        command <= it.op;
        index <= it.index;
        reward <= it.reward;
        row_end <= it.row_end;
        column <= it.column;
        prob <= it.prob;
        do @(posedge clk); while (full);
        items_sent++;
        if (predict_command(it, r))
        begin
            // typed rows: a read of a value that must still be zero
            if (zero_read)
            begin
                r = '0;
                r.kind = 1'b1;
            end
            pending_results.push_back(r);
        end
    endtask

    function automatic sjvi_pkg::item_t make_item(sjvi_pkg::op_t op, int idx,
                                                  logic [63:0] rw, int re,
                                                  int col, logic [32:0] p);
        sjvi_pkg::item_t it;
        it.op = op;
        it.index = idx[13:0];
        it.reward = rw;
        it.row_end = re[14:0];
        it.column = col[9:0];
        it.prob = p;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [32:0] rand_prob();
        case ($urandom_range(0, 3))
            0: return {1'($urandom_range(0, 1)), $urandom};
            1: return 33'h1_0000_0000;
            default: return 33'($urandom_range(0, 32'h3FFF_FFFF));
        endcase
    endfunction

    // Waits out all results and lets the last loads drain before a
    // register write.
    task automatic settle();
        push <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(sjvi_pkg::cfg_idx_t idx, logic [32:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            sjvi_pkg::CFG_N_STATES:   r_n_states = data[10:0];
            sjvi_pkg::CFG_DISCOUNT:   r_discount = data;
            sjvi_pkg::CFG_EPS:        r_eps = data;
            default:                  r_max_sweeps = data[19:0];
        endcase
    endtask

    task automatic configure(logic [10:0] n, logic [32:0] disc, logic [32:0] e,
                             logic [19:0] ms);
        write_reg(sjvi_pkg::CFG_N_STATES, {22'd0, n});
        write_reg(sjvi_pkg::CFG_DISCOUNT, disc);
        write_reg(sjvi_pkg::CFG_EPS, e);
        write_reg(sjvi_pkg::CFG_MAX_SWEEPS, {13'd0, ms});
        cfg_write <= 1'b0;
    endtask

    // One random phase: a complete well-formed problem for the active states,
    // then runs and reads mixed with loads that keep the problem legal.
    task automatic random_phase(int n_eff, int max_per_row);
        int nnz;
        int ends [];
        int order [$];
        int sel;
        int ops;
        int idx;
        ends = new[n_eff];
        nnz = 0;
        for (int i = 0; i < n_eff; i++)
        begin
            nnz += $urandom_range(0, max_per_row);
            ends[i] = nnz;
        end
        for (int k = 0; k < nnz; k++) order.push_back(k);
        order.shuffle();
        foreach (order[k])
            send(make_item(sjvi_pkg::OP_LOAD_NZ, order[k], rand64(), $urandom,
                           $urandom_range(0, n_eff > 1 ? n_eff + 1 : 3), rand_prob()), 0);
        for (int i = 0; i < n_eff; i++)
        begin
            // now and then a row end below its start: an empty row
            idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, nnz) : ends[i];
            send(make_item(sjvi_pkg::OP_LOAD_ROW, i, rand64(), idx, $urandom, $urandom), 0);
        end
        ops = $urandom_range(6, 14);
        for (int j = 0; j < ops; j++)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 3)
                send(make_item(sjvi_pkg::OP_RUN, $urandom, rand64(), $urandom, $urandom,
                               $urandom), 0);
            else if (sel < 6)
            begin
                idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NNZ - 1)
                                                  : $urandom_range(0, n_eff + 1);
                send(make_item(sjvi_pkg::OP_READ, idx, rand64(), $urandom, $urandom,
                               $urandom), 0);
            end
            else if (sel == 6)
                send(make_item(sjvi_pkg::OP_LOAD_ROW, $urandom_range(NSTATES, NNZ - 1),
                               rand64(), $urandom, $urandom, $urandom), 0);
            else if (sel == 7 && nnz > 0)
                send(make_item(sjvi_pkg::OP_LOAD_NZ, $urandom_range(0, nnz - 1), rand64(),
                               $urandom, $urandom, rand_prob()), 0);
            else if (sel == 8)
                send(make_item(sjvi_pkg::OP_LOAD_ROW, $urandom_range(0, n_eff - 1), rand64(),
                               $urandom_range(0, nnz), $urandom, $urandom), 0);
            else
                send(make_item(sjvi_pkg::OP_LOAD_NZ, $urandom_range(nnz, NNZ - 1), rand64(),
                               $urandom, $urandom, rand_prob()), 0);
        end
        send(make_item(sjvi_pkg::OP_RUN, 0, '0, 0, 0, '0), 0);
    endtask

    // Directed rows, at the register values after reset (one state).
    typedef struct {
        sjvi_pkg::op_t op;
        int            idx;
        logic [63:0]   rw;
        int            re;
        int            col;
        logic [32:0]   p;
        bit            zero_read;
    } dir_row_t;

    dir_row_t directed [20] = '{
        '{sjvi_pkg::OP_READ,     0,     64'd0, 0,     0,    33'd0,           1},
        '{sjvi_pkg::OP_READ,     16383, 64'd0, 0,     0,    33'd0,           1},
        '{sjvi_pkg::OP_LOAD_ROW, 0,     S_MIN, 2,     0,    33'd0,           0},
        '{sjvi_pkg::OP_LOAD_ROW, 1023,  S_MAX, 32767, 1023, 33'd0,           0},
        '{sjvi_pkg::OP_LOAD_ROW, 16383, S_MAX, 32767, 0,    33'd0,           0},
        '{sjvi_pkg::OP_LOAD_NZ,  0,     64'd0, 0,     0,    33'h1_FFFF_FFFF, 0},
        '{sjvi_pkg::OP_LOAD_NZ,  1,     64'd0, 0,     1023, 33'd0,           0},
        '{sjvi_pkg::OP_RUN,      0,     64'd0, 0,     0,    33'd0,           0},
        '{sjvi_pkg::OP_READ,     0,     64'd0, 0,     0,    33'd0,           0},
        '{sjvi_pkg::OP_READ,     1023,  64'd0, 0,     0,    33'd0,           0},
        '{sjvi_pkg::OP_LOAD_ROW, 0,     Q_ONE, 1,     0,    33'd0,           0},
        '{sjvi_pkg::OP_RUN,      0,     64'd0, 0,     0,    33'd0,           0},
        '{sjvi_pkg::OP_READ,     0,     64'd0, 0,     0,    33'd0,           0},
        '{sjvi_pkg::OP_READ,     1,     64'd0, 0,     0,    33'd0,           0},
        '{sjvi_pkg::OP_LOAD_NZ,  16383, 64'd0, 0,     5,    33'h1_0000_0000, 0},
        '{sjvi_pkg::OP_LOAD_ROW, 0,     S_MAX, 1,     0,    33'd0,           0},
        '{sjvi_pkg::OP_LOAD_NZ,  0,     64'd0, 0,     0,    33'h0_8000_0000, 0},
        '{sjvi_pkg::OP_RUN,      0,     64'd0, 0,     0,    33'd0,           0},
        '{sjvi_pkg::OP_READ,     0,     64'd0, 0,     0,    33'd0,           0},
        '{sjvi_pkg::OP_READ,     16383, 64'd0, 0,     0,    33'd0,           0}
    };

    initial
    begin
        logic [32:0] disc;
        logic [32:0] e;
        logic [19:0] ms;
        logic [10:0] n;
        int n_eff;
        int phase;
        for (int i = 0; i < NSTATES; i++)
        begin
            m_reward[i] = '0;
            m_row_end[i] = '0;
            bank_a[i] = '0;
            bank_b[i] = '0;
        end
        for (int k = 0; k < NNZ; k++)
        begin
            m_column[k] = '0;
            m_prob[k] = '0;
        end
        bank_sel = 1'b0;
        r_n_states = 11'd1;
        r_discount = 33'd4252017623;
        r_eps = 33'd43;
        r_max_sweeps = 20'd65535;
        error_count = 0;
        items_sent = 0;
        idle_cycles = 0;
        burst_left = 0;
        pop_mode = 0;
        pop_mode_left = 0;

        rst_n <= 1'b0;
        push <= 1'b0;
        pop <= 1'b0;
        command <= sjvi_pkg::OP_LOAD_ROW;
        index <= '0;
        reward <= '0;
        row_end <= '0;
        column <= '0;
        prob <= '0;
        cfg_write <= 1'b0;
        cfg_index <= sjvi_pkg::CFG_N_STATES;
        cfg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[j])
            send(make_item(directed[j].op, directed[j].idx, directed[j].rw,
                           directed[j].re, directed[j].col, directed[j].p),
                 directed[j].zero_read);
        settle();

        // Register extremes first, then random settings until the item
        // budget is spent.
        phase = 0;
        while (items_sent < 420 || phase < 8)
        begin
            case (phase)
                0: begin n = 11'd0; disc = 33'd0; e = 33'd0; ms = 20'hFFFFF; end
                1: begin n = 11'd3; disc = 33'h1_FFFF_FFFF; e = 33'h1_FFFF_FFFF;
                         ms = 20'd0; end
                2: begin n = 11'd4; disc = 33'h1_0000_0000; e = 33'd0; ms = 20'd1; end
                3: begin n = 11'd200; disc = 33'h0_C000_0000; e = 33'd0; ms = 20'd2; end
                default:
                begin
                    n = 11'($urandom_range(1, 8));
                    case ($urandom_range(0, 3))
                        0: disc = 33'd0;
                        1: disc = 33'h1_0000_0000;
                        2: disc = {1'($urandom_range(0, 1)), $urandom};
                        default: disc = {1'b0, $urandom};
                    endcase
                    e = ($urandom_range(0, 1) == 0) ? 33'($urandom_range(0, 65535))
                                                    : {1'($urandom_range(0, 1)), $urandom};
                    ms = (disc == 33'd0) ? 20'hFFFFF : 20'($urandom_range(1, 30));
                end
            endcase
            configure(n, disc, e, ms);
            n_eff = (n < 1) ? 1 : ((n > NSTATES) ? NSTATES : n);
            random_phase(n_eff, n_eff > 16 ? 0 : 4);
            settle();
            phase++;
        end

        while (pending_results.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("PASS sparse_jacobi_value_iteration_core");
        else
            $display("FAIL sparse_jacobi_value_iteration_core");
        $finish;
    end

endmodule
`default_nettype wire
